/* rtl/gregorian_to_lunar_date_defines.svh */
// Assertion macros for the lunar date converter
`ifndef GREGORIAN_TO_LUNAR_DATE_DEFINES_SVH
`define GREGORIAN_TO_LUNAR_DATE_DEFINES_SVH
`ifndef SYNTHESIS
`define G2L_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define G2L_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define G2L_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define G2L_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/g2l_pkg.sv */
// ----------------------------------------------------------------------------
// g2l_pkg
// Types, constants and helpers for the lunar date converter.
// ----------------------------------------------------------------------------
package g2l_pkg;
  localparam int TableDepthDef = 256;
  localparam int BaseYearDef   = 1900;
  localparam int WordW         = 17;
  localparam int CntW          = 9;
  localparam int DayW          = 21;
  // day number of 1900-01-31 in the shifted-epoch scheme
  localparam logic [DayW-1:0] BaseDay = DayW'(146097 * 5 + 365 * 299 + 74 - 2 + 336);

  typedef enum logic [0:0] {KIND_LOAD = 1'b0, KIND_CONV = 1'b1} kind_t;

  typedef struct packed {
    logic [DayW-1:0] rem;
    logic            bad;
  } job_t;

  typedef struct packed {
    logic [11:0] lunar_year;
    logic [3:0]  lunar_month;
    logic [4:0]  lunar_day;
    logic        is_leap_month;
    logic [3:0]  stem_index;
    logic [3:0]  branch_index;
    logic        out_of_range;
  } res_t;

  function automatic logic [3:0] leap_of(input logic [WordW-1:0] w);
    leap_of = (w[3:0] > 4'd12) ? 4'd0 : w[3:0];
  endfunction

  function automatic logic [8:0] year_len(input logic [WordW-1:0] w);
    logic [8:0] t;
    t = 9'd348;
    for (int m = 4; m < 16; m++) t = t + 9'(w[m]);
    if (leap_of(w) != 4'd0) t = t + 9'd29 + 9'(w[16]);
    year_len = t;
  endfunction
endpackage

/* rtl/g2l_if.sv */
// ----------------------------------------------------------------------------
// g2l_in_if / g2l_out_if
// Valid/ready channels of the lunar date converter.
// ----------------------------------------------------------------------------
interface g2l_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  table_index;
  logic [16:0] table_word;
  logic [11:0] solar_year;
  logic [3:0]  solar_month;
  logic [4:0]  solar_day;
  modport source (output valid, kind, table_index, table_word, solar_year,
                  solar_month, solar_day, input ready);
  modport sink (input valid, kind, table_index, table_word, solar_year,
                solar_month, solar_day, output ready);
endinterface

interface g2l_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] lunar_year;
  logic [3:0]  lunar_month;
  logic [4:0]  lunar_day;
  logic        is_leap_month;
  logic [3:0]  stem_index;
  logic [3:0]  branch_index;
  logic        out_of_range;
  modport source (output valid, lunar_year, lunar_month, lunar_day, is_leap_month,
                  stem_index, branch_index, out_of_range, input ready);
  modport sink (input valid, lunar_year, lunar_month, lunar_day, is_leap_month,
                stem_index, branch_index, out_of_range, output ready);
endinterface

/* rtl/g2l_front.sv */
// ----------------------------------------------------------------------------
// g2l_front
// Validates a date and computes days since the base date in states S_A, S_B, S_C.
// ----------------------------------------------------------------------------
module g2l_front import g2l_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] yr,
  input  logic [3:0]  mo,
  input  logic [4:0]  dy,
  output logic        busy,
  output logic        done,
  output job_t        job
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_A = 4'b0010, S_B = 4'b0100, S_C = 4'b1000
  } st_t;
  st_t st_r;
  logic [12:0] yy_r;
  logic [3:0]  mo_r;
  logic [4:0]  dy_r;
  logic [12:0] era_r, yoe_r;
  logic        bad_r;
  logic [DayW-1:0] tgt_r;
  logic [4:0]  mlen;
  logic        gleap;
  logic [3:0]  mp;
  logic [8:0]  doy;
  logic [12:0] era_q;
  logic [26:0] era_m;
  logic [22:0] cen_m;
  logic [5:0]  cen_q;
  logic [6:0]  cen_r;
  logic [8:0]  mdays;
  logic [1:0]  yoe_c;

  always_comb begin
    cen_m = 23'(yr) * 23'd1311;
    cen_q = 6'(cen_m >> 17);
    cen_r = 7'(yr - 12'(cen_q) * 12'd100);
    gleap = yr[1:0] == 2'd0 && (cen_r != 7'd0 || cen_q[1:0] == 2'd0);
    case (mo)
      4'd2: mlen = gleap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
      default: mlen = 5'd31;
    endcase
    mp = (mo_r > 4'd2) ? mo_r - 4'd3 : mo_r + 4'd9;
    case (mp)
      4'd0:  mdays = 9'd0;
      4'd1:  mdays = 9'd31;
      4'd2:  mdays = 9'd61;
      4'd3:  mdays = 9'd92;
      4'd4:  mdays = 9'd122;
      4'd5:  mdays = 9'd153;
      4'd6:  mdays = 9'd184;
      4'd7:  mdays = 9'd214;
      4'd8:  mdays = 9'd245;
      4'd9:  mdays = 9'd275;
      4'd10: mdays = 9'd306;
      4'd11: mdays = 9'd337;
      default: mdays = 9'd0;
    endcase
    doy = mdays + 9'(dy_r) - 9'd1;
    era_m = 27'(yy_r) * 27'd10486;
    era_q = 13'(era_m >> 22);
    if (13'(yy_r - 13'(era_q * 13'd400)) >= 13'd400) era_q = era_q + 13'd1;
    if (yoe_r >= 13'd300) yoe_c = 2'd3;
    else if (yoe_r >= 13'd200) yoe_c = 2'd2;
    else if (yoe_r >= 13'd100) yoe_c = 2'd1;
    else yoe_c = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (start) st_r <= S_A;
        S_A: st_r <= S_B;
        S_B: st_r <= S_C;
        S_C: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
    if (start && st_r == S_IDLE) begin
      yy_r  <= 13'(yr) + 13'd400 - ((mo <= 4'd2) ? 13'd1 : 13'd0);
      mo_r  <= mo;
      dy_r  <= dy;
      bad_r <= mo == 4'd0 || mo > 4'd12 || dy == 5'd0 || dy > mlen;
    end
    if (st_r == S_A) begin
      era_r <= era_q;
      yoe_r <= 13'(yy_r - 13'(era_q * 13'd400));
    end
    if (st_r == S_B)
      tgt_r <= DayW'(era_r) * DayW'(146097) + DayW'(yoe_r) * DayW'(365)
               + DayW'(yoe_r >> 2) - DayW'(yoe_c) + DayW'(doy);
  end

  assign busy = st_r != S_IDLE;
  assign done = st_r == S_C;
  assign job.bad = bad_r || tgt_r < BaseDay;
  assign job.rem = tgt_r - BaseDay;
endmodule

/* rtl/g2l_fifo.sv */
// ----------------------------------------------------------------------------
// g2l_fifo
// Two-entry queue of jobs between front and back.
// ----------------------------------------------------------------------------
module g2l_fifo import g2l_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t dout
);
  job_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) q_r[wp_r] <= din;
  end
  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout = q_r[rp_r];
endmodule

/* rtl/g2l_back.sv */
// ----------------------------------------------------------------------------
// g2l_back
// Holds the year table; walks years then months for each queued job.
// ----------------------------------------------------------------------------
module g2l_back import g2l_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int BASE_YEAR   = BaseYearDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  logic [WordW-1:0]            wr_data,
  input  logic [CntW-1:0]             years_loaded,
  input  logic                        job_valid,
  input  job_t                        job,
  output logic                        job_pop,
  output logic                        idle,
  output logic                        res_valid,
  input  logic                        res_ready,
  output res_t                        res
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int LW = (CntW > AW + 1) ? CntW : AW + 1;
  typedef enum logic [4:0] {
    B_IDLE = 5'b00001, B_RD = 5'b00010, B_YR = 5'b00100, B_MON = 5'b01000,
    B_OUT = 5'b10000
  } bst_t;
  bst_t st_r;
  logic [WordW-1:0] mem [TABLE_DEPTH];
  logic [WordW-1:0] rd_r;
  logic [AW:0]      idx_r;
  logic [DayW-1:0]  rem_r;
  logic [3:0]       m_r;
  logic             inleap_r;
  logic [3:0]       stem_r;
  logic [3:0]       br_r;
  logic [LW-1:0]    limit;
  logic [4:0]       len;
  logic [8:0]       ylen;
  logic [11:0]      ly;
  res_t             res_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[idx_r[AW-1:0]];
  end

  always_comb begin
    limit = (LW'(years_loaded) < LW'(TABLE_DEPTH)) ? LW'(years_loaded) : LW'(TABLE_DEPTH);
    ylen = year_len(rd_r);
    len = inleap_r ? 5'd29 + 5'(rd_r[16]) : 5'd29 + 5'(rd_r[3 + m_r]);
    ly = 12'(BASE_YEAR) + 12'(idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      unique case (st_r)
        B_IDLE: if (job_valid) begin
          rem_r <= job.rem; idx_r <= '0;
          stem_r <= 4'((BASE_YEAR - 4) % 10);
          br_r <= 4'((BASE_YEAR - 4) % 12);
          res_r <= '{out_of_range: 1'b1, default: '0};
          st_r <= (job.bad || limit == '0) ? B_OUT : B_RD;
        end
        B_RD: st_r <= B_YR;
        B_YR: begin
          if (rem_r < DayW'(ylen)) begin
            m_r <= 4'd1; inleap_r <= 1'b0; st_r <= B_MON;
          end else begin
            rem_r <= rem_r - DayW'(ylen);
            idx_r <= idx_r + 1'b1;
            stem_r <= (stem_r == 4'd9) ? 4'd0 : stem_r + 4'd1;
            br_r <= (br_r == 4'd11) ? 4'd0 : br_r + 4'd1;
            st_r <= (LW'(idx_r) + 1'b1 >= limit) ? B_OUT : B_RD;
          end
        end
        B_MON: begin
          if (rem_r < DayW'(len)) begin
            res_r.lunar_year    <= ly;
            res_r.lunar_month   <= m_r;
            res_r.lunar_day     <= 5'(rem_r) + 5'd1;
            res_r.is_leap_month <= inleap_r;
            res_r.stem_index    <= stem_r;
            res_r.branch_index  <= br_r;
            res_r.out_of_range  <= 1'b0;
            st_r <= B_OUT;
          end else begin
            rem_r <= rem_r - DayW'(len);
            if (!inleap_r && leap_of(rd_r) == m_r) inleap_r <= 1'b1;
            else begin
              inleap_r <= 1'b0;
              m_r <= m_r + 4'd1;
              if (m_r == 4'd12) st_r <= B_OUT;
            end
          end
        end
        B_OUT: if (res_ready) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign job_pop = st_r == B_IDLE && job_valid;
  assign idle = st_r == B_IDLE;
  assign res_valid = st_r == B_OUT;
  assign res = res_r;
endmodule

/* rtl/gregorian_to_lunar_date.sv */
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date
// Gregorian to lunar date converter with a loadable year table.
// ----------------------------------------------------------------------------
// channel | dir | handshake   | word
// in_     | in  | valid/ready | kind, table_index, table_word, date
// out_    | out | valid/ready | lunar date, stem, branch, out_of_range
// cfg_    | in  | wr_en       | years_loaded
// A load is accepted only once the front, queue and back are all empty.
// A conversion passes the front states S_A, S_B and S_C, then the back reads and
// checks each year word in turn (B_RD, B_YR) plus up to 13 month steps.
// The year walk through the table, with its one read port, sets the latency.
// Synchronous active-low reset; the table is not cleared.
// A stalled output holds the back; the two-entry queue lets the front go on until it is full.
`include "gregorian_to_lunar_date_defines.svh"
module gregorian_to_lunar_date import g2l_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int BASE_YEAR   = BaseYearDef
) (
  input  logic            clk,
  input  logic            rst_n,
  g2l_in_if.sink          in_ch,
  g2l_out_if.source       out_ch,
  input  logic            cfg_wr_en,
  input  logic [CntW-1:0] cfg_wr_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  logic [CntW-1:0] years_loaded_r;
  logic f_busy, f_done, q_full, q_empty, q_pop, f_start, ld, b_idle;
  job_t f_job, q_job;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) years_loaded_r <= CntW'(201);
    else if (cfg_wr_en) years_loaded_r <= cfg_wr_data;
  end

  assign in_ch.ready = !f_busy && !q_full
                       && (in_ch.kind == KIND_CONV || (q_empty && b_idle));
  assign f_start = in_ch.valid && in_ch.ready && in_ch.kind == KIND_CONV;
  assign ld = in_ch.valid && in_ch.ready && in_ch.kind == KIND_LOAD
              && 32'(in_ch.table_index) < TABLE_DEPTH;

  g2l_front u_front (.clk, .rst_n, .start(f_start), .yr(in_ch.solar_year),
    .mo(in_ch.solar_month), .dy(in_ch.solar_day), .busy(f_busy), .done(f_done),
    .job(f_job));

  g2l_fifo u_fifo (.clk, .rst_n, .push(f_done), .din(f_job), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_job));

  g2l_back #(.TABLE_DEPTH(TABLE_DEPTH), .BASE_YEAR(BASE_YEAR)) u_back (
    .clk, .rst_n, .wr_en(ld), .wr_addr(AW'(in_ch.table_index)),
    .wr_data(in_ch.table_word), .years_loaded(years_loaded_r),
    .job_valid(!q_empty), .job(q_job), .job_pop(q_pop), .idle(b_idle),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res));

  assign out_ch.lunar_year    = res.lunar_year;
  assign out_ch.lunar_month   = res.lunar_month;
  assign out_ch.lunar_day     = res.lunar_day;
  assign out_ch.is_leap_month = res.is_leap_month;
  assign out_ch.stem_index    = res.stem_index;
  assign out_ch.branch_index  = res.branch_index;
  assign out_ch.out_of_range  = res.out_of_range;

  `G2L_ASSERT_IMPL(a_no_push_full, clk, rst_n, f_done, !q_full)
  `G2L_ASSERT_IMPL(a_oor_zero, clk, rst_n, out_ch.valid && out_ch.out_of_range,
    out_ch.lunar_year == 12'd0 && out_ch.lunar_day == 5'd0)
  `G2L_ASSERT_NEXT(a_start_busy, clk, rst_n, f_start, f_busy)
endmodule

/* tb/g2l_tb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2l testbench channels
// The block's own channel interfaces live with the RTL; this file holds
// only the g2l_tb_pkg package with the bench's idle bound IdleMax.
// ----------------------------------------------------------------------------
package g2l_tb_pkg;
  localparam int IdleMax = 10;
endpackage

/* tb/tb_gregorian_to_lunar_date.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gregorian_to_lunar_date
// Loads the year table, converts directed and random Gregorian dates with
// random idling on both channels, a long output stall and several years_loaded
// settings, and compares every result word with a calendar predictor in the bench.
// ----------------------------------------------------------------------------
module tb_gregorian_to_lunar_date;
  import g2l_pkg::*;
  import g2l_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CntW-1:0] cfg_wr_data = '0;

  g2l_in_if in_ch();
  g2l_out_if out_ch();

  gregorian_to_lunar_date dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [16:0] year_words [256];
  int unsigned years_valid;
  res_t lunar_due [$];
  int errors = 0;
  int stall_len = 0;
  int rx_wait = 0;
  bit stall_go = 1'b0;
  bit stall_seen = 1'b0;
  int quiet_cycles = 0;
  localparam int QuietLimit = 20000;

  function automatic bit greg_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned greg_days(int unsigned y, int unsigned m);
    case (m)
      2: return greg_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned day_serial(int unsigned y, int unsigned m, int unsigned d);
    int unsigned yy, era, yoe, mp, doy;
    yy = y + 400 - (m <= 2 ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
  endfunction

  function automatic int unsigned leap_month(logic [16:0] w);
    return (w[3:0] > 12) ? 0 : w[3:0];
  endfunction

  function automatic int unsigned lunar_len(logic [16:0] w);
    int unsigned t;
    t = 0;
    for (int m = 1; m <= 12; m++) t += w[3+m] ? 30 : 29;
    if (leap_month(w) != 0) t += w[16] ? 30 : 29;
    return t;
  endfunction

  function automatic res_t lunar_of(int unsigned y, int unsigned mo, int unsigned d);
    res_t r;
    int unsigned rem, lim, idx, lp, len;
    logic [16:0] w;
    bit found;
    r = '0;
    found = 0;
    idx = 0;
    w = '0;
    if (mo >= 1 && mo <= 12 && d >= 1 && d <= greg_days(y, mo) &&
        day_serial(y, mo, d) >= day_serial(1900, 1, 31)) begin
      rem = day_serial(y, mo, d) - day_serial(1900, 1, 31);
      lim = years_valid < 256 ? years_valid : 256;
      for (idx = 0; idx < lim; idx++) begin
        w = year_words[idx];
        if (rem < lunar_len(w)) begin
          found = 1;
          break;
        end
        rem -= lunar_len(w);
      end
      if (found) begin
        r.lunar_year = 12'(1900 + idx);
        lp = leap_month(w);
        for (int m = 1; m <= 12; m++) begin
          len = w[3+m] ? 30 : 29;
          if (rem < len) begin
            r.lunar_month = 4'(m);
            r.lunar_day = 5'(rem + 1);
            break;
          end
          rem -= len;
          if (lp == m) begin
            len = w[16] ? 30 : 29;
            if (rem < len) begin
              r.lunar_month = 4'(m);
              r.lunar_day = 5'(rem + 1);
              r.is_leap_month = 1'b1;
              break;
            end
            rem -= len;
          end
        end
        r.stem_index = 4'((1900 + idx - 4) % 10);
        r.branch_index = 4'((1900 + idx - 4) % 12);
      end
    end
    if (!found) r = '0;
    r.out_of_range = !found;
    return r;
  endfunction

  task automatic send_word(kind_t k, int unsigned idx, int unsigned w,
                           int unsigned y, int unsigned m, int unsigned d);
    int gap;
    gap = $urandom_range(0, IdleMax);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.table_index <= idx[7:0];
    in_ch.table_word <= w[16:0];
    in_ch.solar_year <= y[11:0];
    in_ch.solar_month <= m[3:0];
    in_ch.solar_day <= d[4:0];
    do @(posedge clk); while (!in_ch.ready);
    if (k == KIND_LOAD) year_words[idx[7:0]] = w[16:0];
    else lunar_due.push_back(lunar_of(y[11:0], m[3:0], d[4:0]));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (lunar_due.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic set_years(int unsigned n);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n[CntW-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    years_valid = n;
  endtask

  task automatic load_table_test();
    for (int i = 0; i < 256; i++) begin
      int unsigned w;
      w = $urandom_range(0, 17'h1ffff);
      if (i == 0) w = 0;
      if (i == 1) w = 17'h1ffff;
      send_word(KIND_LOAD, i, w, 0, 0, 0);
    end
  endtask

  task automatic directed_test();
    send_word(KIND_CONV, 0, 0, 1900, 1, 31);
    send_word(KIND_CONV, 0, 0, 1900, 1, 30);
    send_word(KIND_CONV, 0, 0, 0, 1, 1);
    send_word(KIND_CONV, 0, 0, 4095, 12, 31);
    send_word(KIND_CONV, 0, 0, 2000, 2, 29);
    send_word(KIND_CONV, 0, 0, 1900, 2, 29);
    send_word(KIND_CONV, 0, 0, 2001, 0, 5);
    send_word(KIND_CONV, 0, 0, 2001, 13, 5);
    send_word(KIND_CONV, 0, 0, 2001, 15, 31);
    send_word(KIND_CONV, 0, 0, 2001, 4, 31);
    send_word(KIND_CONV, 0, 0, 2001, 4, 0);
    send_word(KIND_CONV, 0, 0, 1901, 3, 1);
    send_word(KIND_CONV, 0, 0, 2100, 12, 31);
    send_word(KIND_CONV, 0, 0, 2155, 6, 15);
    send_word(KIND_CONV, 0, 0, 2200, 1, 1);
  endtask

  task automatic random_date();
    int unsigned y, m, d;
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) :
        1900 + $urandom_range(0, years_valid < 256 ? years_valid + 2 : 258);
    m = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    d = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) :
        $urandom_range(1, (m >= 1 && m <= 12) ? greg_days(y, m) : 28);
    send_word(KIND_CONV, 0, 0, y, m, d);
  endtask

  task automatic random_test(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_word(KIND_LOAD, $urandom_range(0, 255), $urandom_range(0, 17'h1ffff), 0, 0, 0);
      else random_date();
    end
  endtask

  task automatic pressure_test();
    stall_go = 1'b1;
    for (int i = 0; i < 12; i++) random_date();
  endtask

  always @(posedge clk) begin
    if (stall_go && !stall_seen) begin
      stall_seen = 1'b1;
      stall_len = 3000;
    end
    if (stall_len > 0) begin
      out_ch.ready <= 1'b0;
      stall_len = stall_len - 1;
    end else begin
      if (out_ch.valid && out_ch.ready) rx_wait = $urandom_range(0, IdleMax);
      if (rx_wait > 0) begin
        out_ch.ready <= 1'b0;
        rx_wait = rx_wait - 1;
      end else out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.lunar_year, out_ch.lunar_month, out_ch.lunar_day,
              out_ch.is_leap_month, out_ch.stem_index, out_ch.branch_index,
              out_ch.out_of_range};
      if (lunar_due.size() == 0) begin
        errors++;
        $display("%0t unexpected word %h", $time, got);
      end else begin
        want = lunar_due.pop_front();
        if (got.lunar_year !== want.lunar_year) begin
          errors++; $display("%0t lunar_year exp %0d got %0d", $time, want.lunar_year, got.lunar_year);
        end
        if (got.lunar_month !== want.lunar_month) begin
          errors++; $display("%0t lunar_month exp %0d got %0d", $time, want.lunar_month, got.lunar_month);
        end
        if (got.lunar_day !== want.lunar_day) begin
          errors++; $display("%0t lunar_day exp %0d got %0d", $time, want.lunar_day, got.lunar_day);
        end
        if (got.is_leap_month !== want.is_leap_month) begin
          errors++; $display("%0t is_leap exp %0d got %0d", $time, want.is_leap_month, got.is_leap_month);
        end
        if (got.stem_index !== want.stem_index) begin
          errors++; $display("%0t stem exp %0d got %0d", $time, want.stem_index, got.stem_index);
        end
        if (got.branch_index !== want.branch_index) begin
          errors++; $display("%0t branch exp %0d got %0d", $time, want.branch_index, got.branch_index);
        end
        if (got.out_of_range !== want.out_of_range) begin
          errors++; $display("%0t oor exp %0d got %0d", $time, want.out_of_range, got.out_of_range);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (lunar_due.size() == 0 && !in_ch.valid) || stall_len > 0)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.table_index = '0;
    in_ch.table_word = '0;
    in_ch.solar_year = '0;
    in_ch.solar_month = '0;
    in_ch.solar_day = '0;
    years_valid = 201;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_table_test();
    directed_test();
    random_test(300);
    pressure_test();
    set_years(256);
    random_test(300);
    set_years(1);
    random_test(150);
    set_years(0);
    random_test(50);
    set_years(511);
    random_test(300);
    set_years(100);
    random_test(300);
    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/g2l_pkg.sv
rtl/g2l_if.sv
rtl/g2l_front.sv
rtl/g2l_fifo.sv
rtl/g2l_back.sv
rtl/gregorian_to_lunar_date.sv
tb/g2l_tb_if.sv
tb/tb_gregorian_to_lunar_date.sv
